>>> src/ptc_pkg.sv
// ---------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure and temperature compensation
// pipeline.
// ---------------------------------------------------------------------------
package ptc_pkg;

	// calibration register index
	typedef enum logic [2:0] {
		CAL_T1_T2 = 3'd0,
		CAL_T3_P1 = 3'd1,
		CAL_P2_P3 = 3'd2,
		CAL_P4_P5 = 3'd3,
		CAL_P6_P7 = 3'd4,
		CAL_P8_P9 = 3'd5
	} cal_idx_t;

	localparam int CAL_IDX_W = 3;
	localparam int CAL_W     = 32;

	// divider geometry: numerator |m|*3125, divisor |d|, quotient bits kept
	localparam int NUM_W = 75;
	localparam int DEN_W = 48;
	localparam int QUO_W = 38;

	localparam logic [11:0] SCALE_K = 12'd3125;
	localparam logic [QUO_W-2:0] QMAX = '1;

	// per-request side information that travels alongside the divider
	typedef struct packed {
		logic               neg;   // quotient sign negative, result clamps to 0
		logic               zero;  // divisor is zero
		logic               ovf;   // quotient does not fit QUO_W bits
		logic signed [15:0] tc;    // finished temperature
	} ptc_side_t;

endpackage

>>> src/ptc_div.sv
// ---------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider, one quotient bit per stage, with an up-front
// overflow check on the high part of the numerator.
// ---------------------------------------------------------------------------
module ptc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [ptc_pkg::NUM_W-1:0]   num,
	input  logic [ptc_pkg::DEN_W-1:0]   den,
	input  ptc_pkg::ptc_side_t          side_in,
	output logic                        out_valid,
	output logic [ptc_pkg::QUO_W-1:0]   quo,
	output ptc_pkg::ptc_side_t          side_out
);

	localparam int Steps = ptc_pkg::QUO_W;
	localparam int DenW  = ptc_pkg::DEN_W;
	localparam int NumW  = ptc_pkg::NUM_W;

	logic                    vld_sn  [Steps+1];
	logic [DenW-1:0]         rem_sn  [Steps+1];
	logic [DenW-1:0]         den_sn  [Steps+1];
	logic [Steps-1:0]        low_sn  [Steps+1];
	logic [Steps-1:0]        quo_sn  [Steps+1];
	ptc_pkg::ptc_side_t      side_sn [Steps+1];

	logic [DenW-1:0] head;
	assign head = DenW'(num[NumW-1:Steps]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Steps; k++) vld_sn[k] <= 1'b0;
		end else if (adv) begin
			vld_sn[0] <= in_valid;
			for (int k = 0; k < Steps; k++) vld_sn[k+1] <= vld_sn[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sn[0]      <= head;
			den_sn[0]      <= den;
			low_sn[0]      <= num[Steps-1:0];
			quo_sn[0]      <= '0;
			side_sn[0]     <= '{neg: side_in.neg, zero: side_in.zero,
			                    ovf: (head >= den), tc: side_in.tc};
		end
	end

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [DenW:0] trial;
		logic [DenW:0] diff;
		logic          fit;
		assign trial = {rem_sn[k], low_sn[k][Steps-1-k]};
		assign diff  = trial - {1'b0, den_sn[k]};
		assign fit   = (trial >= {1'b0, den_sn[k]});

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[k+1]  <= fit ? diff[DenW-1:0] : trial[DenW-1:0];
				den_sn[k+1]  <= den_sn[k];
				low_sn[k+1]  <= low_sn[k];
				quo_sn[k+1]  <= {quo_sn[k][Steps-2:0], fit};
				side_sn[k+1] <= side_sn[k];
			end
		end
	end

	assign out_valid = vld_sn[Steps];
	assign quo       = quo_sn[Steps];
	assign side_out  = side_sn[Steps];

endmodule

>>> src/pressure_temperature_compensation_top.sv
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Integer compensation of raw barometric sensor readings into temperature
// (centi-degrees) and pressure (Pa, Q24.8).
// ---------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready) takes one request of raw_temperature
//   and raw_pressure; output channel (out_valid/out_ready) returns one result
//   of temperature_centi, pressure_q24_8 and divide_fault per request.
// - calibration sits in six 32-bit registers written through cfg_we,
//   cfg_index and cfg_data; write them only while no request is in flight.
//   Indexes six and seven are ignored.
// - a new request is taken every cycle unless the receiver stalls; the
//   38-stage quotient chain sets most of the pipeline depth.
// - when the receiver stalls the whole pipeline holds in place and in_ready
//   drops the same cycle; nothing is dropped or repeated.
// - reset clears all valid bits and the calibration registers to zero.
// - a zero pressure divisor returns pressure 0 with divide_fault set.
// ---------------------------------------------------------------------------
module pressure_temperature_compensation_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ptc_pkg::CAL_IDX_W-1:0]    cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [19:0]                      raw_temperature,
	input  logic [19:0]                      raw_pressure,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [15:0]               temperature_centi,
	output logic [31:0]                      pressure_q24_8,
	output logic                             divide_fault
);

	// calibration registers
	logic [31:0] cal_t1_t2_q, cal_t3_p1_q, cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_t2_q <= '0;
			cal_t3_p1_q <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptc_pkg::CAL_T1_T2: cal_t1_t2_q <= cfg_data;
				ptc_pkg::CAL_T3_P1: cal_t3_p1_q <= cfg_data;
				ptc_pkg::CAL_P2_P3: cal_p2_p3_q <= cfg_data;
				ptc_pkg::CAL_P4_P5: cal_p4_p5_q <= cfg_data;
				ptc_pkg::CAL_P6_P7: cal_p6_p7_q <= cfg_data;
				ptc_pkg::CAL_P8_P9: cal_p8_p9_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = cal_t1_t2_q[15:0];
	assign t2 = $signed(cal_t1_t2_q[31:16]);
	assign t3 = $signed(cal_t3_p1_q[15:0]);
	assign p1 = cal_t3_p1_q[31:16];
	assign p2 = $signed(cal_p2_p3_q[15:0]);
	assign p3 = $signed(cal_p2_p3_q[31:16]);
	assign p4 = $signed(cal_p4_p5_q[15:0]);
	assign p5 = $signed(cal_p4_p5_q[31:16]);
	assign p6 = $signed(cal_p6_p7_q[15:0]);
	assign p7 = $signed(cal_p6_p7_q[31:16]);
	assign p8 = $signed(cal_p8_p9_q[15:0]);
	assign p9 = $signed(cal_p8_p9_q[31:16]);

	// whole pipeline moves together
	logic adv;
	assign adv      = out_ready || !out_valid;
	assign in_ready = adv;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_d, vld_pa, vld_pb;

	// raw pressure rides along until the numerator is formed
	logic [19:0] raw_pressure_s1, raw_pressure_s2, raw_pressure_s3, raw_pressure_s4;
	logic [19:0] raw_pressure_s5, raw_pressure_s6, raw_pressure_s7, raw_pressure_s8;

	// stage 1: offsets
	logic signed [18:0] a_c, a_s1;
	logic signed [17:0] b_c, b_s1;
	assign a_c = $signed({2'b0, raw_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
	assign b_c = $signed({2'b0, raw_temperature[19:4]}) - $signed({2'b0, t1});

	// stage 2: first products
	logic signed [34:0] at_c, at_s2;
	logic signed [35:0] bb_c;
	logic signed [20:0] bb12_s2;
	assign at_c = 35'(a_s1) * 35'(t2);
	assign bb_c = 36'(b_s1) * 36'(b_s1);

	// stage 3
	logic signed [36:0] bt_c, bt_s3;
	logic signed [23:0] tfa_s3;
	assign bt_c = 37'(bb12_s2) * 37'(t3);

	// stage 4: t_fine
	logic signed [23:0] tf_c, tf_s4;
	assign tf_c = tfa_s3 + 24'(bt_s3 >>> 14);

	// stage 5: temperature and offset for pressure
	logic signed [27:0] t5_c, tcs_c;
	logic signed [15:0] tc_c, tc_s5;
	logic signed [24:0] e_s5;
	assign t5_c  = 28'(tf_s4) * 28'sd5 + 28'sd128;
	assign tcs_c = t5_c >>> 8;
	always_comb begin
		priority if (tcs_c > 28'sd32767) tc_c = 16'sh7FFF;
		else if (tcs_c < -28'sd32768)    tc_c = 16'sh8000;
		else                             tc_c = tcs_c[15:0];
	end

	// stage 6
	logic signed [47:0] ee_s6;
	logic signed [40:0] ep5_s6, ep2_s6;
	logic signed [15:0] tc_s6;

	// stage 7
	logic signed [63:0] ee6_s7, ee3_s7;
	logic signed [40:0] ep5_s7, ep2_s7;
	logic signed [15:0] tc_s7;

	// stage 8: divisor seed and numerator offset
	logic signed [63:0] g_c, h_c, g_s8, big_s8;
	logic signed [15:0] tc_s8;
	assign g_c = ee6_s7 + (64'(ep5_s7) <<< 17) + (64'(p4) <<< 35);
	assign h_c = (ee3_s7 >>> 8) + (64'(ep2_s7) <<< 12);

	// stage 9: split product big*P1
	logic signed [47:0] hi_c;
	logic signed [63:0] hp_s9, m_s9, m_c;
	logic [32:0]        lp_s9;
	logic [20:0]        pd_c;
	logic signed [15:0] tc_s9;
	assign hi_c = 48'(big_s8 >>> 17);
	assign pd_c = {1'b1, 20'b0} - {1'b0, raw_pressure_s8};
	assign m_c  = $signed({12'b0, pd_c, 31'b0}) - g_s8;

	// stage 10
	logic signed [63:0] dsum_c;
	logic signed [47:0] d_s10;
	logic signed [63:0] m_s10;
	logic signed [15:0] tc_s10;
	assign dsum_c = hp_s9 + $signed({48'b0, lp_s9[32:17]});

	// stage 11: magnitudes and scaled numerator
	logic [63:0]                   mm_c;
	logic [47:0]                   dm_c;
	logic [ptc_pkg::NUM_W-1:0]     n_s11;
	logic [ptc_pkg::DEN_W-1:0]     dm_s11;
	ptc_pkg::ptc_side_t            side_s11;
	assign mm_c = m_s10[63] ? (64'd0 - m_s10) : m_s10;
	assign dm_c = d_s10[47] ? (48'd0 - d_s10) : d_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1            <= a_c;
			b_s1            <= b_c;
			raw_pressure_s1 <= raw_pressure;

			at_s2           <= at_c;
			bb12_s2         <= $signed({1'b0, bb_c[31:12]});
			raw_pressure_s2 <= raw_pressure_s1;

			bt_s3           <= bt_c;
			tfa_s3          <= 24'(at_s2 >>> 11);
			raw_pressure_s3 <= raw_pressure_s2;

			tf_s4           <= tf_c;
			raw_pressure_s4 <= raw_pressure_s3;

			e_s5            <= 25'(tf_s4) - 25'sd128000;
			tc_s5           <= tc_c;
			raw_pressure_s5 <= raw_pressure_s4;

			ee_s6           <= 48'(e_s5) * 48'(e_s5);
			ep5_s6          <= 41'(e_s5) * 41'(p5);
			ep2_s6          <= 41'(e_s5) * 41'(p2);
			tc_s6           <= tc_s5;
			raw_pressure_s6 <= raw_pressure_s5;

			ee6_s7          <= 64'(ee_s6) * 64'(p6);
			ee3_s7          <= 64'(ee_s6) * 64'(p3);
			ep5_s7          <= ep5_s6;
			ep2_s7          <= ep2_s6;
			tc_s7           <= tc_s6;
			raw_pressure_s7 <= raw_pressure_s6;

			g_s8            <= g_c;
			big_s8          <= 64'sh0000_8000_0000_0000 + h_c;
			tc_s8           <= tc_s7;
			raw_pressure_s8 <= raw_pressure_s7;

			hp_s9           <= 64'(hi_c) * 64'($signed({1'b0, p1}));
			lp_s9           <= {16'b0, big_s8[16:0]} * {17'b0, p1};
			m_s9            <= m_c;
			tc_s9           <= tc_s8;

			d_s10           <= 48'(dsum_c >>> 16);
			m_s10           <= m_s9;
			tc_s10          <= tc_s9;

			n_s11           <= ptc_pkg::NUM_W'(mm_c[62:0]) *
			                   ptc_pkg::NUM_W'(ptc_pkg::SCALE_K);
			dm_s11          <= dm_c;
			side_s11        <= '{neg: (m_s10[63] != d_s10[47]), zero: (d_s10 == 48'sd0),
			                     ovf: 1'b0, tc: tc_s10};
		end
	end

	// quotient chain
	logic [ptc_pkg::QUO_W-1:0] quo_d;
	ptc_pkg::ptc_side_t        side_d;

	ptc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s11),
		.num       (n_s11),
		.den       (dm_s11),
		.side_in   (side_s11),
		.out_valid (vld_d),
		.quo       (quo_d),
		.side_out  (side_d)
	);

	// post stage a: clamp quotient, start correction terms
	logic [ptc_pkg::QUO_W-2:0] q_c, q_pa, q_pb;
	logic [23:0]               s_c;
	logic [47:0]               ss_pa;
	logic signed [53:0]        p8q_pa;
	ptc_pkg::ptc_side_t        side_pa, side_pb;
	always_comb begin
		if (side_d.neg)                                  q_c = '0;
		else if (side_d.ovf || quo_d[ptc_pkg::QUO_W-1])  q_c = ptc_pkg::QMAX;
		else                                             q_c = quo_d[ptc_pkg::QUO_W-2:0];
	end
	assign s_c = q_c[36:13];

	// post stage b
	logic signed [39:0] c1_pb;
	logic signed [34:0] c2_pb;
	logic signed [64:0] c1_c;
	assign c1_c = 65'(p9) * $signed({17'b0, ss_pa});

	// output stage
	logic signed [41:0] r_c, r8_c, rr_c;
	logic [31:0]        press_c;
	assign r_c  = $signed({5'b0, q_pb}) + 42'(c1_pb) + 42'(c2_pb);
	assign r8_c = r_c >>> 8;
	assign rr_c = r8_c + (42'(p7) <<< 4);
	always_comb begin
		priority if (side_pb.zero)              press_c = '0;
		else if (rr_c < 42'sd0)                 press_c = '0;
		else if (rr_c > 42'sh0_FFFF_FFFF)       press_c = '1;
		else                                    press_c = rr_c[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pa    <= 1'b0;
			vld_pb    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_pa    <= vld_d;
			vld_pb    <= vld_pa;
			out_valid <= vld_pb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_pa              <= q_c;
			ss_pa             <= s_c * s_c;
			p8q_pa            <= 54'(p8) * $signed({17'b0, q_c});
			side_pa           <= side_d;

			q_pb              <= q_pa;
			c1_pb             <= 40'(c1_c >>> 25);
			c2_pb             <= 35'(p8q_pa >>> 19);
			side_pb           <= side_pa;

			temperature_centi <= side_pb.tc;
			pressure_q24_8    <= press_c;
			divide_fault      <= side_pb.zero;
		end
	end

	// checks
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> pressure_q24_8 == 32'd0)
		else $error("fault result carries nonzero pressure");

	a_out_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without handshake");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s11) && $stable(vld_d))
		else $error("pipeline moved during stall");

endmodule

>>> dv/pressure_temperature_compensation_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_checker
// Watches the calibration port and both channels, predicts each compensated
// reading from its own copy of the calibration and compares results in order.
// ---------------------------------------------------------------------------
module pressure_temperature_compensation_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptc_pkg::CAL_IDX_W-1:0] cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [19:0]                   raw_temperature,
	input  logic [19:0]                   raw_pressure,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [15:0]            temperature_centi,
	input  logic [31:0]                   pressure_q24_8,
	input  logic                          divide_fault,
	output int                            errors,
	output int                            pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [15:0] tc;
		logic [31:0]        press;
		logic               fault;
	} reading_t;

	logic [31:0] cal [6];
	reading_t    readings_due [$];

	function automatic wide_t sgn16(logic [15:0] v);
		return wide_t'($signed(v));
	endfunction

	function automatic wide_t uns16(logic [15:0] v);
		return wide_t'(v);
	endfunction

	function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
		wide_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		wide_t a, b, tf, tc, e, g, h, big, d, m, mm, dm, q, s, c1, c2, r;
		wide_t qmax;
		reading_t res;
		t1 = uns16(cal[ptc_pkg::CAL_T1_T2][15:0]);  t2 = sgn16(cal[ptc_pkg::CAL_T1_T2][31:16]);
		t3 = sgn16(cal[ptc_pkg::CAL_T3_P1][15:0]);  p1 = uns16(cal[ptc_pkg::CAL_T3_P1][31:16]);
		p2 = sgn16(cal[ptc_pkg::CAL_P2_P3][15:0]);  p3 = sgn16(cal[ptc_pkg::CAL_P2_P3][31:16]);
		p4 = sgn16(cal[ptc_pkg::CAL_P4_P5][15:0]);  p5 = sgn16(cal[ptc_pkg::CAL_P4_P5][31:16]);
		p6 = sgn16(cal[ptc_pkg::CAL_P6_P7][15:0]);  p7 = sgn16(cal[ptc_pkg::CAL_P6_P7][31:16]);
		p8 = sgn16(cal[ptc_pkg::CAL_P8_P9][15:0]);  p9 = sgn16(cal[ptc_pkg::CAL_P8_P9][31:16]);
		qmax = (wide_t'(1) <<< 37) - 1;

		a = wide_t'(adc_t >> 3) - 2 * t1;
		b = wide_t'(adc_t >> 4) - t1;
		tf = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
		tc = (tf * 5 + 128) >>> 8;
		if (tc > 32767) tc = 32767;
		if (tc < -32768) tc = -32768;
		res.tc = tc[15:0];
		res.press = '0;
		res.fault = 1'b0;

		e = tf - 128000;
		g = e * e * p6 + e * p5 * (wide_t'(1) <<< 17) + p4 * (wide_t'(1) <<< 35);
		h = ((e * e * p3) >>> 8) + e * p2 * 4096;
		big = (wide_t'(1) <<< 47) + h;
		d = (big * p1) >>> 33;
		if (d == 0) begin
			res.fault = 1'b1;
		end else begin
			m = (wide_t'(1048576) - wide_t'(adc_p)) * (wide_t'(1) <<< 31) - g;
			mm = (m < 0) ? -m : m;
			dm = (d < 0) ? -d : d;
			q = (mm * 3125) / dm;
			if (q > qmax) q = qmax;
			if ((m < 0) != (d < 0)) q = 0;
			s = q >>> 13;
			c1 = (p9 * s * s) >>> 25;
			c2 = (p8 * q) >>> 19;
			r = ((q + c1 + c2) >>> 8) + p7 * 16;
			if (r < 0) r = 0;
			if (r > 128'sh0FFFFFFFF) r = 128'sh0FFFFFFFF;
			res.press = r[31:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			foreach (cal[i]) cal[i] <= '0;
			readings_due.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we && cfg_index < 6)
				cal[cfg_index] <= cfg_data;
			if (in_valid && in_ready)
				readings_due.push_back(compensate(raw_temperature, raw_pressure));
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected result t=%0d p=%h f=%b", $time,
						temperature_centi, pressure_q24_8, divide_fault);
					errors <= errors + 1;
				end else begin
					want = readings_due.pop_front();
					if (want.tc !== temperature_centi || want.press !== pressure_q24_8 ||
							want.fault !== divide_fault) begin
						$display("%0t: mismatch expected t=%0d p=%h f=%b actual t=%0d p=%h f=%b",
							$time, want.tc, want.press, want.fault,
							temperature_centi, pressure_q24_8, divide_fault);
						errors <= errors + 1;
					end
				end
			end
			pending <= readings_due.size();
		end
	end
endmodule

>>> dv/pressure_temperature_compensation_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_top_tb
// Drives raw sensor readings under several calibration sets with random
// handshake gaps; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module pressure_temperature_compensation_top_tb;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [ptc_pkg::CAL_IDX_W-1:0] cfg_index = '0;
	logic [ptc_pkg::CAL_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [19:0]                   raw_temperature = '0;
	logic [19:0]                   raw_pressure = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [15:0]            temperature_centi;
	logic [31:0]                   pressure_q24_8;
	logic                          divide_fault;
	int                            errors;
	int                            pending;

	int sender_gap_pct = 26;
	int receiver_gap_pct = 86;
	int sent = 0;

	logic [31:0] cal_set [6];

	always #2 clk = ~clk;

	pressure_temperature_compensation_top DUT (.*);

	pressure_temperature_compensation_checker checker_i (.*);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= receiver_gap_pct);

	task automatic send(input logic [19:0] t, input logic [19:0] p);
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= t;
		raw_pressure <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
		// idle profile follows progress through the run
		if (sent == 417) begin
			sender_gap_pct = 86;
			receiver_gap_pct = 26;
		end else if (sent == 834) begin
			sender_gap_pct = 0;
			receiver_gap_pct = 0;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic load_cal();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= ptc_pkg::CAL_IDX_W'(i);
			cfg_data <= cal_set[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_reading();
		if ($urandom_range(1))
			send(20'($urandom_range(560000, 480000)), 20'($urandom_range(500000, 250000)));
		else
			send(20'($urandom), 20'($urandom));
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// calibration at reset: zero divisor everywhere
		send(20'h00000, 20'h00000);
		send(20'hFFFFF, 20'hFFFFF);
		send(20'h7EEB0, 20'h655AC);

		// typical sensor calibration
		cal_set = '{{16'sd26435, 16'd27504}, {16'd36477, -16'sd1000},
			{16'sd3024, -16'sd10685}, {16'sd140, 16'sd2855},
			{16'sd15500, -16'sd7}, {16'sd6000, -16'sd14600}};
		drain();
		load_cal();
		send(20'h7EEB0, 20'h655AC);
		send(20'h00000, 20'h00000);
		send(20'hFFFFF, 20'hFFFFF);
		send(20'h00000, 20'hFFFFF);
		send(20'hFFFFF, 20'h00000);
		send(20'hAAAAA, 20'h55555);
		send(20'h55555, 20'hAAAAA);
		send(20'h80000, 20'h80000);
		send(20'h6B780, 20'h40000);
		send(20'h90000, 20'h20000);
		send(20'h00001, 20'hFFFFE);
		send(20'h70000, 20'h00001);
		for (int i = 0; i < 150; i++) random_reading();

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			case (ph)
				0: cal_set = '{default: 32'hFFFF_FFFF};
				1: cal_set = '{default: 32'h7FFF_7FFF};
				2: cal_set = '{default: 32'h8000_8000};
				3: cal_set = '{default: 32'h0001_0001};
				default: foreach (cal_set[i]) cal_set[i] = $urandom;
			endcase
			if (ph == 4) begin
				// out-of-range indexes must leave calibration alone
				cfg_we <= 1'b1;
				cfg_index <= 3'd6;
				cfg_data <= 32'hDEAD_BEEF;
				@(negedge clk);
				cfg_index <= 3'd7;
				@(negedge clk);
				cfg_we <= 1'b0;
			end
			load_cal();
			send(20'h00000, 20'h00000);
			send(20'hFFFFF, 20'hFFFFF);
			for (int i = 0; i < 150; i++) random_reading();
		end

		drain();
		repeat (60) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> sim.f
src/ptc_pkg.sv
src/ptc_div.sv
src/pressure_temperature_compensation_top.sv
dv/pressure_temperature_compensation_checker.sv
dv/pressure_temperature_compensation_top_tb.sv
